[design/pcx_pkg.sv]
`default_nettype none
package pcx_pkg;

  // Tour storage depth and derived widths
  localparam int MAX_CITIES = 32;
  localparam int CITY_W     = 5;
  localparam int CITY_IDS   = 1 << CITY_W;
  localparam int POS_W      = $clog2(MAX_CITIES);
  localparam int CNT_W      = $clog2(MAX_CITIES + 1);
  localparam int CMP_W      = (CNT_W > CITY_W) ? CNT_W : CITY_W;

  // Stream widths, padded to whole bytes
  localparam int IN_TDATA_W  = ((3 * CITY_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((CITY_W + 7) / 8) * 8;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;         // store one position of both parents
    logic start;        // last position: latch cut and tour length
    logic skip;         // second parent city already taken, step the walk
    logic place;        // write the next child city to the output register
    logic take_second;  // placed city comes from the second parent
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic use_first;     // child position lies before the cut
    logic walk_done;     // second parent exhausted
    logic second_taken;  // current second parent city already placed
    logic final_pos;     // child position is the last of the tour
    logic out_busy;      // output register holds an untaken transaction
  } stat_t;

endpackage
`default_nettype wire

[design/pcx_datapath.sv]
`default_nettype none
module pcx_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire pcx_pkg::cmd_t                  cmd,
  output pcx_pkg::stat_t                      stat,
  input  wire logic [pcx_pkg::CITY_W-1:0]     in_first,
  input  wire logic [pcx_pkg::CITY_W-1:0]     in_second,
  input  wire logic [pcx_pkg::CITY_W-1:0]     in_cut,
  output logic      [pcx_pkg::CITY_W-1:0]     child_city,
  output logic                                child_last,
  output logic                                out_valid,
  input  wire logic                           out_ready
);

  // Parent stores, one read port each
  logic [pcx_pkg::CITY_W-1:0] first_mem  [pcx_pkg::MAX_CITIES];
  logic [pcx_pkg::CITY_W-1:0] second_mem [pcx_pkg::MAX_CITIES];
  logic [pcx_pkg::CITY_W-1:0] first_q;
  logic [pcx_pkg::CITY_W-1:0] second_q;

  logic [pcx_pkg::CNT_W-1:0]    load_count;
  logic [pcx_pkg::CNT_W-1:0]    load_count_next;
  logic [pcx_pkg::CNT_W-1:0]    n_len;
  logic [pcx_pkg::CITY_W-1:0]   saved_cut;
  logic [pcx_pkg::POS_W-1:0]    pos;
  logic [pcx_pkg::CNT_W-1:0]    walk;
  logic [pcx_pkg::CITY_IDS-1:0] taken;

  logic                         store_full;
  logic                         store_we;
  logic [pcx_pkg::CITY_W-1:0]   place_city;

  // Load bookkeeping: positions beyond the store are dropped
  assign store_full      = (load_count == pcx_pkg::CNT_W'(pcx_pkg::MAX_CITIES));
  assign store_we        = cmd.load && !store_full;
  assign load_count_next = store_full ? load_count : load_count + pcx_pkg::CNT_W'(1);
  assign place_city      = cmd.take_second ? second_q : first_q;

  // Status to the controller
  assign stat.use_first    = pcx_pkg::CMP_W'(pos) < pcx_pkg::CMP_W'(saved_cut);
  assign stat.walk_done    = (walk >= n_len);
  assign stat.second_taken = taken[second_q];
  assign stat.final_pos    = (pcx_pkg::CNT_W'(pos) + pcx_pkg::CNT_W'(1)) == n_len;
  assign stat.out_busy     = out_valid && !out_ready;

  // Parent stores: write on load, registered read at the child position and walk
  always_ff @(posedge clk) begin
    if (store_we) begin
      first_mem[load_count[pcx_pkg::POS_W-1:0]]  <= in_first;
      second_mem[load_count[pcx_pkg::POS_W-1:0]] <= in_second;
    end
    first_q  <= first_mem[pos];
    second_q <= second_mem[walk[pcx_pkg::POS_W-1:0]];
  end

  // Job counters, taken map and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      n_len      <= '0;
      saved_cut  <= '0;
      pos        <= '0;
      walk       <= '0;
      taken      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready && !cmd.place) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        load_count <= load_count_next;
      end
      if (cmd.start) begin
        n_len     <= load_count_next;
        saved_cut <= in_cut;
        pos       <= '0;
        walk      <= '0;
      end
      if (cmd.skip) begin
        walk <= walk + pcx_pkg::CNT_W'(1);
      end
      if (cmd.place) begin
        child_city <= place_city;
        child_last <= stat.final_pos;
        out_valid  <= 1'b1;
        if (cmd.take_second) begin
          walk <= walk + pcx_pkg::CNT_W'(1);
        end
        // last child city ends the job
        if (stat.final_pos) begin
          taken      <= '0;
          load_count <= '0;
        end else begin
          taken[place_city] <= 1'b1;
          pos               <= pos + pcx_pkg::POS_W'(1);
        end
      end
    end
  end

  // Checks
  a_place_free: assert property (@(posedge clk) disable iff (rst)
    cmd.place |-> !(out_valid && !out_ready))
    else $error("child city placed over an untaken transaction");

  a_skip_taken: assert property (@(posedge clk) disable iff (rst)
    cmd.skip |-> taken[second_q])
    else $error("second parent city skipped though not taken");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    walk <= n_len)
    else $error("second parent walk ran past the tour length");

  a_job_end: assert property (@(posedge clk) disable iff (rst)
    (cmd.place && stat.final_pos) |=> (load_count == '0 && taken == '0))
    else $error("job state not cleared after the last child city");

endmodule
`default_nettype wire

[design/pcx_ctrl.sv]
`default_nettype none
module pcx_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic           in_last,
  output logic                in_ready,
  input  wire pcx_pkg::stat_t stat,
  output pcx_pkg::cmd_t       cmd
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_FETCH,
    ST_DECIDE
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_LOAD);

  // Command decode and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        cmd.load  = in_valid;
        cmd.start = in_valid && in_last;
        if (in_valid && in_last) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        priority if (stat.out_busy) begin
          state_next = ST_DECIDE;
        end else if (stat.use_first || stat.walk_done) begin
          cmd.place  = 1'b1;
          state_next = stat.final_pos ? ST_LOAD : ST_FETCH;
        end else if (stat.second_taken) begin
          cmd.skip   = 1'b1;
          state_next = ST_FETCH;
        end else begin
          cmd.place       = 1'b1;
          cmd.take_second = 1'b1;
          state_next      = stat.final_pos ? ST_LOAD : ST_FETCH;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

[design/permutation_crossover_core.sv]
`default_nettype none
// One-point order crossover of two parent tours. Each input transaction loads
// one city of each parent, one per cycle; the transaction with tlast set also
// carries the cut and starts the job. The child tour then leaves one city per
// transaction, tlast on its final city: positions before the cut copy the
// first parent, later positions take the second parent's cities in order,
// skipping cities already placed, and fall back to the first parent's city
// once the second parent is exhausted. Each child position passes a fetch
// state, the registered read of the parent stores, then a decide state, which
// waits while the output register holds an untaken transaction; every skipped
// second-parent city adds another fetch and decide. No new parent is accepted
// until the last child city is placed in the output register. Up to 32
// positions are held; further positions of a job are dropped.
module permutation_crossover_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // [4:0] city_from_first, [9:5] city_from_second, [14:10] cut_point
  input  wire logic [pcx_pkg::IN_TDATA_W-1:0]      s_tdata,
  input  wire logic                                s_tlast,    // last_city
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // [4:0] child_city
  output logic      [pcx_pkg::OUT_TDATA_W-1:0]     m_tdata,
  output logic                                     m_tlast     // child_last
);

  pcx_pkg::cmd_t               cmd;
  pcx_pkg::stat_t              stat;
  logic [pcx_pkg::CITY_W-1:0]  child_city;

  pcx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pcx_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_first   (s_tdata[pcx_pkg::CITY_W-1:0]),
    .in_second  (s_tdata[2*pcx_pkg::CITY_W-1:pcx_pkg::CITY_W]),
    .in_cut     (s_tdata[3*pcx_pkg::CITY_W-1:2*pcx_pkg::CITY_W]),
    .child_city (child_city),
    .child_last (m_tlast),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready)
  );

  // Output packing
  assign m_tdata = pcx_pkg::OUT_TDATA_W'(child_city);

endmodule
`default_nettype wire

[tb/sv/tb_permutation_crossover_core.sv]
`timescale 1ns / 1ps
`default_nettype none
module tb_permutation_crossover_core;

  localparam int CW         = pcx_pkg::CITY_W;
  localparam int IN_W       = pcx_pkg::IN_TDATA_W;
  localparam int OUT_W      = pcx_pkg::OUT_TDATA_W;
  localparam int TOUR_MAX   = pcx_pkg::MAX_CITIES;
  localparam int HOLD_LEN   = 300;
  localparam int TAIL_WAIT  = 200;

  typedef logic [CW-1:0] city_t;

  // one input transaction: a position of both parents, cut read on the last
  typedef struct packed {
    city_t first;
    city_t second;
    city_t cut;
    logic  last;
  } parent_pos_t;

  // one child city as it should leave the block
  typedef struct packed {
    city_t city;
    logic  last;
  } child_city_t;

  logic             clk;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             s_tlast = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tlast;

  parent_pos_t pending_positions[$];
  child_city_t child_expected[$];

  // predictor state
  city_t first_tour[TOUR_MAX];
  city_t second_tour[TOUR_MAX];
  int    held_positions = 0;

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_go = 1'b0;
  int  hold_left = 0;
  int  positions_queued = 0;
  int  positions_accepted = 0;
  int  accepts_seen = 0;
  int  children_checked = 0;
  int  jobs_done = 0;
  int  over_length_jobs = 0;
  int  walk_ran_out = 0;
  int  errors = 0;

  parent_pos_t next_pos;
  logic [IN_W-1:0] next_word;
  child_city_t want;

  permutation_crossover_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("tb_permutation_crossover_core failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, exp_val);
    errors++;
  endtask

  // store one position; on the last one build the whole child tour
  task automatic cross_parents(input parent_pos_t pos);
    logic [31:0] placed;
    city_t       city;
    child_city_t c;
    int          n;
    int          walk;
    int          i;
    if (held_positions < TOUR_MAX) begin
      first_tour[held_positions]  = pos.first;
      second_tour[held_positions] = pos.second;
      held_positions++;
    end
    if (pos.last) begin
      n      = held_positions;
      walk   = 0;
      placed = '0;
      for (i = 0; i < n; i++) begin
        if (i < int'(pos.cut)) begin
          city = first_tour[i];
        end else begin
          while (walk < n && placed[second_tour[walk]]) walk++;
          if (walk < n) begin
            city = second_tour[walk];
            walk++;
          end else begin
            city = first_tour[i];
            walk_ran_out++;
          end
        end
        placed[city] = 1'b1;
        c.city = city;
        c.last = (i == n - 1);
        child_expected.insert(child_expected.size(), c);
      end
      held_positions = 0;
      jobs_done++;
    end
  endtask

  task automatic add_position(input city_t a, input city_t b, input city_t cut, input bit last);
    parent_pos_t p;
    p.first  = a;
    p.second = b;
    p.cut    = cut;
    p.last   = last;
    pending_positions.insert(pending_positions.size(), p);
    positions_queued++;
  endtask

  // a job of len positions; parents are permutations of the same cities unless
  // scrambled, and positions past the store depth carry random cities
  task automatic queue_job(input int len, input int cut, input bit scrambled);
    city_t pool[32];
    city_t order2[32];
    city_t tmp;
    int    k;
    int    j;
    int    t;
    for (j = 0; j < 32; j++) pool[j] = city_t'(j);
    for (j = 31; j > 0; j--) begin
      t = $urandom_range(j);
      tmp = pool[j]; pool[j] = pool[t]; pool[t] = tmp;
    end
    k = (len < TOUR_MAX) ? len : TOUR_MAX;
    for (j = 0; j < k; j++) order2[j] = pool[j];
    for (j = k - 1; j > 0; j--) begin
      t = $urandom_range(j);
      tmp = order2[j]; order2[j] = order2[t]; order2[t] = tmp;
    end
    for (j = 0; j < len; j++) begin
      if (scrambled || j >= TOUR_MAX)
        add_position(city_t'($urandom_range(31)), city_t'($urandom_range(31)),
                     (j == len - 1) ? city_t'(cut) : city_t'($urandom_range(31)),
                     j == len - 1);
      else
        add_position(pool[j], order2[j],
                     (j == len - 1) ? city_t'(cut) : city_t'($urandom_range(31)),
                     j == len - 1);
    end
    if (len > TOUR_MAX) over_length_jobs++;
  endtask

  // mostly short well-formed tours, some long, a few past the store depth
  task automatic random_job();
    int r;
    int len;
    int cut;
    r = $urandom_range(99);
    if (r < 8)
      len = $urandom_range(TOUR_MAX + 4, TOUR_MAX);
    else if (r < 20)
      len = $urandom_range(TOUR_MAX - 1, 11);
    else
      len = $urandom_range(10, 2);
    r = $urandom_range(99);
    if (r < 10)
      cut = 0;
    else if (r < 20)
      cut = $urandom_range(31);
    else
      cut = $urandom_range((len < 31) ? len : 31, 0);
    queue_job(len, cut, $urandom_range(99) < 12);
  endtask

  task automatic drain();
    while (pending_positions.size() != 0 || s_tvalid || child_expected.size() != 0)
      @(posedge clk);
  endtask

  // input side: present the next queued position once the last one is taken
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || positions_accepted != accepts_seen) begin
      accepts_seen = positions_accepted;
      if (pending_positions.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_pos  = pending_positions.pop_front();
        next_word = '0;
        next_word[3*CW-1:0] = {next_pos.cut, next_pos.second, next_pos.first};
        s_tdata  <= next_word;
        s_tlast  <= next_pos.last;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // output side ready, random idling plus the long hold-off
  always @(negedge clk) begin
    m_tready <= !rst && hold_left == 0 && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (hold_go)
      hold_left <= HOLD_LEN;
    else if (hold_left != 0)
      hold_left <= hold_left - 1;
  end

  // accepted input transactions feed the predictor
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      cross_parents({s_tdata[CW-1:0], s_tdata[2*CW-1:CW], s_tdata[3*CW-1:2*CW], s_tlast});
      positions_accepted++;
    end
  end

  // accepted output transactions against the oldest expected child city
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      children_checked++;
      if (child_expected.size() == 0) begin
        report_mismatch("child city with none pending", int'(m_tdata[CW-1:0]), -1);
      end else begin
        want = child_expected.pop_front();
        if (m_tdata[CW-1:0] !== want.city)
          report_mismatch("child_city", int'(m_tdata[CW-1:0]), int'(want.city));
        if (m_tlast !== want.last)
          report_mismatch("child_last", int'(m_tlast), int'(want.last));
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // phase one: sender idles a little, receiver a lot
    send_idle_pct = 15;
    recv_idle_pct = 66;

    // single-city tour
    queue_job(1, 0, 1'b0);
    // cut zero, child drawn wholly from the second parent
    queue_job(4, 0, 1'b0);
    // cut at top of range, first parent unchanged
    queue_job(4, 31, 1'b0);
    // cut equal to tour length
    queue_job(5, 5, 1'b0);
    // parents not permutations: second parent runs out, extreme city values
    add_position(city_t'(0),  city_t'(31), city_t'(0),  1'b0);
    add_position(city_t'(31), city_t'(0),  city_t'(31), 1'b0);
    add_position(city_t'(0),  city_t'(31), city_t'(31), 1'b0);
    add_position(city_t'(31), city_t'(0),  city_t'(0),  1'b0);
    add_position(city_t'(0),  city_t'(31), city_t'(2),  1'b1);
    // ordinary cut inside the tour
    queue_job(3, 1, 1'b0);
    while (positions_queued < 120) random_job();
    drain();

    // phase two: roles swapped
    send_idle_pct = 66;
    recv_idle_pct = 15;
    while (positions_queued < 235) random_job();
    drain();

    // phase three: no idling, with one long receiver hold-off
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (positions_queued < 350) random_job();
    repeat (20) @(negedge clk);
    hold_go = 1'b1;
    @(negedge clk);
    hold_go = 1'b0;
    drain();
    repeat (TAIL_WAIT) @(posedge clk);

    $display("covered %0d parent transactions in %0d jobs, %0d of them past the store depth",
             positions_accepted, jobs_done, over_length_jobs);
    $display("checked %0d child cities, second parent ran out on %0d positions",
             children_checked, walk_ran_out);
    if (errors == 0)
      $display("tb_permutation_crossover_core passed");
    else
      $display("tb_permutation_crossover_core failed");
    $finish;
  end

endmodule
`default_nettype wire
